/* design/assert_macros.svh */
// Assertion macros shared by the texel fetch RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/tfu_pkg.sv */
// Constants, register indexes and helpers of the texel fetch unit.
package tfu_pkg;
	localparam int MEM_BYTES = 65536;
	localparam int ADDR_W    = $clog2(MEM_BYTES);

	localparam logic [2:0] REG_DIMS   = 3'd0;
	localparam logic [2:0] REG_SIZE0  = 3'd1;
	localparam logic [2:0] REG_SIZE1  = 3'd2;
	localparam logic [2:0] REG_SIZE2  = 3'd3;
	localparam logic [2:0] REG_STRIDE0 = 3'd4;
	localparam logic [2:0] REG_STRIDE1 = 3'd5;
	localparam logic [2:0] REG_FLIP   = 3'd6;
	localparam logic [2:0] REG_FORMAT = 3'd7;

	localparam logic       CMD_WRITE  = 1'b0;
	localparam logic       CMD_LOOKUP = 1'b1;

	localparam logic [1:0] MODE_REPEAT = 2'd0;
	localparam logic [1:0] MODE_CLAMP  = 2'd1;

	localparam logic [2:0] SLOT_END = 3'd0;
	localparam logic [2:0] SLOT_R   = 3'd1;
	localparam logic [2:0] SLOT_A   = 3'd4;

	localparam logic [15:0] CHAN_ABSENT = 16'hFFFF;

	typedef logic [15:0] half_t;

	// Slots ahead of the first end code, padding included.
	function automatic logic [2:0] texel_bytes(input logic [11:0] fmt);
		logic [2:0] n;
		logic       run;
		n   = 3'd0;
		run = 1'b1;
		for (int s = 0; s < 4; s++) begin
			if (run && fmt[3*s +: 3] != SLOT_END)
				n = n + 3'd1;
			else
				run = 1'b0;
		end
		return n;
	endfunction
endpackage

/* design/texture_texel_address_fetch_unit.sv */
// Texel fetch unit: coordinate wrap/clamp/flip, address build and byte memory.
//
//  channel   beat          tdata fields (low first)
//  s_axis    write/lookup  write_address, write_data, coord_d0..2, mode_d0..2
//  m_axis    texel result  texel_address, red, green, blue, alpha
//  cfg       register      cfg_we / cfg_index / cfg_wdata
//
// A write beat is taken in ST_IDLE. A lookup runs per dimension ST_PREP, ST_MUL and
// ST_STEP, with ST_DIV after ST_PREP for a repeat dimension (one quotient bit a cycle
// in the shared remainder unit), then ST_READ for byte reads from the memory's registered
// read port and ST_OUT to hand off. The output register frees the input
// side while a result waits. Reset clears control only; memory is undefined.
module texture_texel_address_fetch_unit import tfu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// write_address[15:0], write_data[23:16], coord_d0[55:24], coord_d1[87:56],
	// coord_d2[119:88], mode_d0[121:120], mode_d1[123:122], mode_d2[125:124]
	input  logic [127:0] s_axis_tdata,
	// command
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// texel_address[15:0], red[31:16], green[47:32], blue[63:48], alpha[79:64]
	output logic [79:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_wdata
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_STEP = 3'd4;
	localparam logic [2:0] ST_READ = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [1:0]  dims_q;
	half_t       size_q [3];
	half_t       stride_q [2];
	logic [2:0]  flip_q;
	logic [11:0] fmt_q;

	logic [2:0]  state_q;
	logic [1:0]  dim_q;
	logic [31:0] coord_q [3];
	logic [1:0]  mode_q [3];
	half_t       sz_q, step_q, offset_q, c_q, rem_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [4:0]  cnt_q;
	logic [2:0]  rd_q;
	logic [2:0]  tb_q;
	half_t       chan_q [4];
	logic [7:0]  rd_data_q;
	logic [7:0]  mem [MEM_BYTES];

	logic        in_acc;
	half_t       sz_raw, sz_eff;
	logic [31:0] crd;
	logic [1:0]  md;
	half_t       clamp_c;
	logic [16:0] rem_sh;
	half_t       rem_n, rem_fix;
	logic        mem_we;
	logic [ADDR_W-1:0] rd_addr;
	logic [2:0]  slot_idx;
	logic [2:0]  slot_code;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign mem_we        = in_acc && (s_axis_tuser == CMD_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q   <= 2'd2;
			size_q   <= '{16'd1, 16'd1, 16'd1};
			stride_q <= '{16'd0, 16'd0};
			flip_q   <= 3'd0;
			fmt_q    <= 12'd2257;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIMS:    dims_q      <= cfg_wdata[1:0];
				REG_SIZE0:   size_q[0]   <= cfg_wdata;
				REG_SIZE1:   size_q[1]   <= cfg_wdata;
				REG_SIZE2:   size_q[2]   <= cfg_wdata;
				REG_STRIDE0: stride_q[0] <= cfg_wdata;
				REG_STRIDE1: stride_q[1] <= cfg_wdata;
				REG_FLIP:    flip_q      <= cfg_wdata[2:0];
				REG_FORMAT:  fmt_q       <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sz_raw  = size_q[dim_q];
		sz_eff  = (sz_raw == 16'd0) ? 16'd1 : sz_raw;
		crd     = coord_q[dim_q];
		md      = mode_q[dim_q];
		if (crd[31])
			clamp_c = 16'd0;
		else if (crd[30:0] >= {15'd0, sz_eff})
			clamp_c = sz_eff - 16'd1;
		else
			clamp_c = crd[15:0];
		rem_sh  = {rem_q, mag_q[31]};
		rem_n   = (rem_sh >= {1'b0, sz_q}) ? 16'(rem_sh - {1'b0, sz_q}) : rem_sh[15:0];
		rem_fix = (neg_q && rem_n != 16'd0) ? sz_q - rem_n : rem_n;
		rd_addr = ADDR_W'(offset_q + {13'd0, rd_q});
		slot_idx  = rd_q - 3'd1;
		slot_code = fmt_q[3*slot_idx[1:0] +: 3];
	end

	// Memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[s_axis_tdata[ADDR_W-1:0]] <= s_axis_tdata[23:16];
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				coord_q[0] <= s_axis_tdata[55:24];
				coord_q[1] <= s_axis_tdata[87:56];
				coord_q[2] <= s_axis_tdata[119:88];
				mode_q[0]  <= s_axis_tdata[121:120];
				mode_q[1]  <= s_axis_tdata[123:122];
				mode_q[2]  <= s_axis_tdata[125:124];
				tb_q       <= texel_bytes(fmt_q);
				step_q     <= {13'd0, texel_bytes(fmt_q)};
				offset_q   <= 16'd0;
				rd_q       <= 3'd0;
				chan_q     <= '{CHAN_ABSENT, CHAN_ABSENT, CHAN_ABSENT, CHAN_ABSENT};
			end
			ST_PREP: begin
				sz_q  <= sz_eff;
				mag_q <= crd[31] ? 32'(-crd) : crd;
				neg_q <= crd[31];
				rem_q <= 16'd0;
				cnt_q <= 5'd0;
				if (md == MODE_CLAMP)
					c_q <= flip_q[dim_q] ? sz_eff - 16'd1 - clamp_c : clamp_c;
				else
					c_q <= flip_q[dim_q] ? sz_eff - 16'd1 - crd[15:0] : crd[15:0];
			end
			ST_DIV: begin
				rem_q <= rem_n;
				mag_q <= {mag_q[30:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				c_q   <= flip_q[dim_q] ? sz_q - 16'd1 - rem_fix : rem_fix;
			end
			ST_MUL: offset_q <= offset_q + 16'(step_q * c_q);
			ST_STEP: begin
				if (dim_q != 2'd2 && stride_q[dim_q[0]] != 16'd0)
					step_q <= stride_q[dim_q[0]];
				else
					step_q <= 16'(step_q * sz_q);
			end
			ST_READ: begin
				rd_q <= rd_q + 3'd1;
				// Later slots overwrite earlier ones of the same channel.
				if (rd_q != 3'd0 && slot_idx < tb_q
				    && slot_code >= SLOT_R && slot_code <= SLOT_A)
					chan_q[2'(slot_code - SLOT_R)] <= {rd_data_q, rd_data_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dim_q   <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					dim_q <= 2'd0;
					if (in_acc && s_axis_tuser == CMD_LOOKUP)
						state_q <= (dims_q == 2'd0) ? ST_READ : ST_PREP;
				end
				ST_PREP: state_q <= (md == MODE_REPEAT) ? ST_DIV : ST_MUL;
				ST_DIV:  if (cnt_q == 5'd31) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_STEP;
				ST_STEP: begin
					dim_q   <= dim_q + 2'd1;
					state_q <= (dim_q + 2'd1 == dims_q) ? ST_READ : ST_PREP;
				end
				ST_READ: if (rd_q == 3'd4) state_q <= ST_OUT;
				ST_OUT:  if (!m_axis_tvalid || m_axis_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (state_q == ST_OUT && (!m_axis_tvalid || m_axis_tready))
			m_axis_tvalid <= 1'b1;
		else if (m_axis_tready)
			m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!m_axis_tvalid || m_axis_tready))
			m_axis_tdata <= {chan_q[3], chan_q[2], chan_q[1], chan_q[0], offset_q};
	end

`include "assert_macros.svh"
	`ASSERT_NEXT(a_lookup_start, in_acc && s_axis_tuser == CMD_LOOKUP,
		state_q == ST_PREP || state_q == ST_READ)
	`ASSERT_IMPL(a_rem_below_size, state_q == ST_DIV, rem_q < sz_q)
	`ASSERT_NEXT(a_out_hold, state_q == ST_OUT && m_axis_tvalid && !m_axis_tready,
		state_q == ST_OUT)
endmodule

/* bench/tb_texture_texel_address_fetch_unit.sv */
// Testbench for the texel fetch unit: self-predicting, random stalls, checked per beat.
module tb_texture_texel_address_fetch_unit;
	import tfu_pkg::*;

	localparam logic [1:0] MODE_NONE  = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [2:0] SLOT_G = 3'd2;
	localparam logic [2:0] SLOT_B = 3'd3;
	localparam logic [2:0] SLOT_X = 3'd5;
	localparam logic [2:0] SLOT_SPARE = 3'd6;
	localparam int STALL_LIMIT = 6000;
	localparam int HOLD_CYCLES = 800;

	typedef struct packed {
		logic [15:0] addr;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
	} texel_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [79:0]  m_axis_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [15:0]  cfg_wdata;

	texture_texel_address_fetch_unit dut (.*);

	// Shadow copy of the block's registers and texture bytes.
	logic [1:0]  dims_q;
	logic [15:0] size_q [3];
	logic [15:0] stride_q [2];
	logic [2:0]  flip_q;
	logic [11:0] format_q;
	logic [7:0]  tex_mem [MEM_BYTES];
	bit          tex_set [MEM_BYTES];

	texel_t texel_queue[$];
	int  errors;
	int  lookups_sent;
	int  writes_sent;
	int  texels_checked;
	int  idle_cycles;
	bit  send_gaps;
	bit  recv_gaps;
	bit  hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint wrap_mem(input longint v);
		longint r;
		r = v % MEM_BYTES;
		if (r < 0)
			r += MEM_BYTES;
		return r;
	endfunction

	function automatic int texel_span();
		int n;
		n = 0;
		while (n < 4 && format_q[3*n +: 3] != SLOT_END)
			n++;
		return n;
	endfunction

	function automatic longint texel_offset(input logic [127:0] d);
		int     ndims;
		longint step;
		longint offset;
		longint size;
		longint c;
		logic [1:0] mode;
		ndims  = (dims_q > 3) ? 3 : dims_q;
		step   = texel_span();
		offset = 0;
		for (int k = 0; k < ndims; k++) begin
			size = (size_q[k] == 0) ? 1 : size_q[k];
			c    = longint'(signed'(d[24 + 32*k +: 32]));
			mode = d[120 + 2*k +: 2];
			if (mode == MODE_REPEAT) begin
				c = c % size;
				if (c < 0)
					c += size;
			end else if (mode == MODE_CLAMP) begin
				if (c < 0)
					c = 0;
				if (c >= size)
					c = size - 1;
			end
			if (flip_q[k])
				c = size - 1 - c;
			offset = (offset + step * wrap_mem(c)) % MEM_BYTES;
			if (k < 2 && stride_q[k] != 0)
				step = stride_q[k];
			else
				step = (step * size) % MEM_BYTES;
		end
		return offset;
	endfunction

	function automatic texel_t fetch_texel(input logic [127:0] d);
		texel_t t;
		logic [2:0] code;
		int     nbytes;
		longint offset;
		logic [15:0] chan [4];
		nbytes = texel_span();
		offset = texel_offset(d);
		for (int s = 0; s < 4; s++)
			chan[s] = CHAN_ABSENT;
		for (int s = 0; s < nbytes; s++) begin
			code = format_q[3*s +: 3];
			if (code >= SLOT_R && code <= SLOT_A)
				chan[code - 1] = {2{tex_mem[(offset + s) % MEM_BYTES]}};
		end
		t.addr  = offset[15:0];
		t.red   = chan[0];
		t.green = chan[1];
		t.blue  = chan[2];
		t.alpha = chan[3];
		return t;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		errors++;
	endtask

	// Drive one beat, wait for it to be taken, then predict.
	task automatic send_beat(input logic cmd, input logic [127:0] data, input bit no_gap = 0);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= data;
		do @(posedge clk); while (!s_axis_tready);
		if (cmd == CMD_WRITE) begin
			tex_mem[data[15:0]] = data[23:16];
			tex_set[data[15:0]] = 1'b1;
			writes_sent++;
		end else begin
			texel_queue.push_back(fetch_texel(data));
			lookups_sent++;
		end
		gap = (send_gaps && !no_gap) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Write any channel byte the lookup reads that holds no data yet, then send the lookup.
	task automatic send_lookup(input logic [127:0] data, input bit no_gap = 0);
		logic [127:0] w;
		logic [2:0]   code;
		logic [15:0]  addr;
		int           nbytes;
		longint       offset;
		nbytes = texel_span();
		offset = texel_offset(data);
		for (int s = 0; s < nbytes; s++) begin
			code = format_q[3*s +: 3];
			addr = 16'((offset + s) % MEM_BYTES);
			if (code >= SLOT_R && code <= SLOT_A && !tex_set[addr]) begin
				w = {$urandom, $urandom, $urandom, $urandom};
				w[15:0] = addr;
				send_beat(CMD_WRITE, w, no_gap);
			end
		end
		send_beat(CMD_LOOKUP, data, no_gap);
	endtask

	task automatic idle_sender();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain();
		idle_sender();
		while (texel_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DIMS:    dims_q      = val[1:0];
			REG_SIZE0:   size_q[0]   = val;
			REG_SIZE1:   size_q[1]   = val;
			REG_SIZE2:   size_q[2]   = val;
			REG_STRIDE0: stride_q[0] = val;
			REG_STRIDE1: stride_q[1] = val;
			REG_FLIP:    flip_q      = val[2:0];
			REG_FORMAT:  format_q    = val[11:0];
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [1:0] dm, input logic [15:0] s0, input logic [15:0] s1,
			input logic [15:0] s2, input logic [15:0] t0, input logic [15:0] t1,
			input logic [2:0] fl, input logic [11:0] fmt);
		write_reg(REG_DIMS, 16'(dm));
		write_reg(REG_SIZE0, s0);
		write_reg(REG_SIZE1, s1);
		write_reg(REG_SIZE2, s2);
		write_reg(REG_STRIDE0, t0);
		write_reg(REG_STRIDE1, t1);
		write_reg(REG_FLIP, 16'(fl));
		write_reg(REG_FORMAT, 16'(fmt));
	endtask

	function automatic logic [127:0] lookup_beat(input logic [31:0] c0, input logic [31:0] c1,
			input logic [31:0] c2, input logic [1:0] m0, input logic [1:0] m1,
			input logic [1:0] m2);
		logic [127:0] d;
		d = '0;
		d[15:0]    = 16'($urandom);
		d[23:16]   = 8'($urandom);
		d[55:24]   = c0;
		d[87:56]   = c1;
		d[119:88]  = c2;
		d[121:120] = m0;
		d[123:122] = m1;
		d[125:124] = m2;
		return d;
	endfunction

	function automatic logic [31:0] pick_coord(input logic [15:0] size);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 32'($urandom_range(0, 2 * size + 8)) - 32'(size) - 32'd4;
		if (r < 9)
			return $urandom;
		return r[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

	task automatic send_random_beat(input bit no_gap = 0);
		logic [127:0] d;
		d = lookup_beat(pick_coord(size_q[0]), pick_coord(size_q[1]), pick_coord(size_q[2]),
			2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
		if ($urandom_range(0, 9) < 3) begin
			d[127:24] = {$urandom, $urandom, $urandom, 8'($urandom)};
			send_beat(CMD_WRITE, d, no_gap);
		end else begin
			send_lookup(d, no_gap);
		end
	endtask

	task automatic test_directed();
		// Defaults from reset first, then coordinate extremes in every mode.
		send_lookup(lookup_beat(0, 0, 0, MODE_REPEAT, MODE_REPEAT, MODE_REPEAT));
		drain();
		set_all(2'd3, 16'd7, 16'd5, 16'd3, 16'd0, 16'd0, 3'd0, {SLOT_A, SLOT_B, SLOT_G, SLOT_R});
		send_lookup(lookup_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			MODE_REPEAT, MODE_REPEAT, MODE_REPEAT));
		send_lookup(lookup_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			MODE_CLAMP, MODE_CLAMP, MODE_CLAMP));
		send_lookup(lookup_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			MODE_NONE, MODE_SPARE, MODE_NONE));
		send_lookup(lookup_beat(32'd6, 32'd4, 32'd2, MODE_CLAMP, MODE_NONE,
			MODE_SPARE));
		// Overwrite a byte and read it straight back.
		send_beat(CMD_WRITE, {104'd0, 8'hFF, 16'hFFFF});
		send_lookup(lookup_beat(32'hFFFF_FFFF, 0, 0, MODE_NONE, MODE_NONE,
			MODE_NONE));
		drain();
		// Flips, padding, spare codes, repeated channel, short formats.
		set_all(2'd3, 16'd4, 16'd3, 16'd2, 16'd0, 16'd0, 3'd7,
			{SLOT_R, SLOT_X, SLOT_SPARE, SLOT_R});
		send_lookup(lookup_beat(1, 2, 1, MODE_REPEAT, MODE_CLAMP, MODE_NONE));
		send_lookup(lookup_beat(-5, 9, -1, MODE_REPEAT, MODE_CLAMP, MODE_REPEAT));
		drain();
		write_reg(REG_FORMAT, 16'({SLOT_A, SLOT_END, SLOT_G, SLOT_B}));
		send_lookup(lookup_beat(3, 1, 0, MODE_REPEAT, MODE_REPEAT, MODE_REPEAT));
		drain();
		write_reg(REG_FORMAT, 16'd0);
		send_lookup(lookup_beat(3, 1, 0, MODE_REPEAT, MODE_REPEAT, MODE_REPEAT));
		drain();
		// Zero sizes, no dimensions, explicit strides.
		set_all(2'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 3'd7, 12'hFFF);
		send_lookup(lookup_beat(9, 9, 9, MODE_NONE, MODE_NONE, MODE_NONE));
		drain();
		set_all(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 12'hFFF);
		send_lookup(lookup_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF, MODE_CLAMP,
			MODE_REPEAT, MODE_NONE));
		send_lookup(lookup_beat(-1, -1, -1, MODE_REPEAT, MODE_REPEAT, MODE_REPEAT));
		drain();
	endtask

	task automatic test_random_phases();
		int start;
		for (int p = 0; p < 8; p++) begin
			if (p % 3 == 0)
				set_all(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 3'($urandom), 12'($urandom));
			else
				set_all(2'($urandom_range(1, 3)), 16'($urandom_range(0, 9)),
					16'($urandom_range(0, 9)), 16'($urandom_range(0, 9)),
					($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 300))),
					($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 3000))),
					3'($urandom), 12'($urandom));
			send_gaps = (p % 4 != 1);
			recv_gaps = (p % 4 != 2);
			start = writes_sent + lookups_sent;
			while (writes_sent + lookups_sent - start < 160)
				send_random_beat();
			drain();
		end
		send_gaps = 1;
		recv_gaps = 1;
	endtask

	// Hold the output side off while offering 60 beats, so that the input stalls.
	task automatic test_backpressure();
		set_all(2'd2, 16'd6, 16'd5, 16'd1, 16'd0, 16'd0, 3'd2, {SLOT_A, SLOT_B, SLOT_G, SLOT_R});
		@(negedge clk);
		hold_req = 1'b1;
		for (int i = 0; i < 60; i++)
			send_random_beat(1);
		drain();
	endtask

	// Output side: random stalls, plus one long counted hold when asked.
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (recv_gaps && pick_gap() > 0) begin
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		texel_t want;
		texel_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = texel_t'({m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
				m_axis_tdata[63:48], m_axis_tdata[79:64]});
			if (texel_queue.size() == 0) begin
				$display("unexpected texel beat %h at %0t", m_axis_tdata, $time);
				errors++;
			end else begin
				want = texel_queue.pop_front();
				if (got.addr !== want.addr)
					report("texel_address", got.addr, want.addr);
				if (got.red !== want.red)
					report("red", got.red, want.red);
				if (got.green !== want.green)
					report("green", got.green, want.green);
				if (got.blue !== want.blue)
					report("blue", got.blue, want.blue);
				if (got.alpha !== want.alpha)
					report("alpha", got.alpha, want.alpha);
				texels_checked++;
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout with %0d texels outstanding", texel_queue.size());
			$display("tb_texture_texel_address_fetch_unit: errors");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_WRITE;
		cfg_we        = 1'b0;
		cfg_index     = REG_DIMS;
		cfg_wdata     = '0;
		errors        = 0;
		lookups_sent  = 0;
		writes_sent   = 0;
		texels_checked = 0;
		idle_cycles   = 0;
		send_gaps     = 1;
		recv_gaps     = 1;
		hold_req      = 0;
		dims_q        = 2'd2;
		size_q        = '{16'd1, 16'd1, 16'd1};
		stride_q      = '{16'd0, 16'd0};
		flip_q        = 3'd0;
		format_q      = 12'd2257;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random_phases();
		test_backpressure();
		repeat (50) @(posedge clk);
		$display("covered %0d byte writes and %0d lookups, %0d texels compared",
			writes_sent, lookups_sent, texels_checked);
		$display("register sweeps included zero and full sizes, strides, flips and formats");
		if (errors == 0 && texel_queue.size() == 0)
			$display("tb_texture_texel_address_fetch_unit: clean");
		else
			$display("tb_texture_texel_address_fetch_unit: errors");
		$finish;
	end
endmodule
